// File: design/pcwd_pkg.sv
// ----------------------------------------------------------------------------
// pcwd_pkg: shared definitions for the pulse counter with durations
// Field widths, stream bit positions, the item kind codes and the per-channel
// result record used by the counter unit.
// ----------------------------------------------------------------------------
package pcwd_pkg;

    // Default and largest number of channels the unit can watch.
    localparam int CHANNELS_DEF = 8;
    localparam int MAX_CH       = 8;

    // Field widths.
    localparam int LEVELS_W = 8;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 32;
    localparam int CH_W     = 3;

    // Slave-side tdata layout, lowest bit first.
    localparam int S_LEVELS_LSB = 0;
    localparam int S_NOW_LSB    = S_LEVELS_LSB + LEVELS_W;
    localparam int S_PG_BIT     = S_NOW_LSB + TIME_W;
    localparam int S_PCH_LSB    = S_PG_BIT + 1;
    localparam int S_PCNT_LSB   = S_PCH_LSB + CH_W;
    localparam int S_USED_W     = S_PCNT_LSB + CNT_W;
    localparam int S_TDATA_W    = ((S_USED_W + 7) / 8) * 8;

    // Master-side tdata layout, lowest bit first.
    localparam int M_CH_LSB    = 0;
    localparam int M_CNT_LSB   = M_CH_LSB + CH_W;
    localparam int M_ON_LSB    = M_CNT_LSB + CNT_W;
    localparam int M_OFF_LSB   = M_ON_LSB + TIME_W;
    localparam int M_ACT_BIT   = M_OFF_LSB + TIME_W;
    localparam int M_RISE_BIT  = M_ACT_BIT + 1;
    localparam int M_FALL_BIT  = M_RISE_BIT + 1;
    localparam int M_POLL_BIT  = M_FALL_BIT + 1;
    localparam int M_USED_W    = M_POLL_BIT + 1;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    // Kind of an incoming transaction, carried in tuser.
    typedef enum logic {
        MODE_POLL    = 1'b0,
        MODE_PRELOAD = 1'b1
    } t_mode;

    // What one channel reports after a poll.
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
        logic              active;
        logic              rise;
        logic              fall;
    } t_chan_result;

endpackage

// File: design/pulse_counter_with_durations_unit.sv
// ----------------------------------------------------------------------------
// pulse_counter_with_durations_unit: multi-channel pulse counter
// Counts activations of active-low inputs and tracks on-time and off-time
// per channel from a millisecond time stamp carried by each poll.
// ----------------------------------------------------------------------------
// A poll transaction on the slave side is evaluated for all channels at once
// in the cycle it is accepted: the per-channel state is updated and a snapshot
// of every channel's result is captured. The snapshot is then sent on the
// master side as one transaction per channel, channel 0 first, with tlast on
// the final channel. A poll therefore occupies the master side until all NCH
// results (eight by default) are taken, and that drain of the snapshot buffer
// sets the sustained poll rate. The next poll is taken in the same cycle as
// the last result of the previous one. A preload transaction (tuser set)
// writes one channel's count and produces no output. Only the first eight
// channels exist, as the levels field has eight bits; CHANNELS above eight
// behaves as eight. When the power-good bit is low a poll changes no state
// but still reports every channel with polled cleared. Off-time stays zero
// while a channel's count is zero.
// ----------------------------------------------------------------------------
module pulse_counter_with_durations_unit #(
    parameter int CHANNELS = pcwd_pkg::CHANNELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Slave side.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: levels[7:0], now_ms[39:8], power_good[40], preload_channel[43:41],
    //        preload_count[75:44], zero padding[79:76]
    input  logic [pcwd_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: mode[0]
    input  logic                           i_s_axis_tuser,
    // Master side.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata: channel[2:0], event_count[34:3], on_time_ms[66:35],
    //        off_time_ms[98:67], is_active[99], became_active[100],
    //        became_inactive[101], polled[102], zero padding[103]
    output logic [pcwd_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // tlast: last
    output logic                           o_m_axis_tlast
);
    import pcwd_pkg::*;

    // Channels that really exist, and the width of a channel index.
    localparam int NCH   = (CHANNELS > MAX_CH) ? MAX_CH : ((CHANNELS < 1) ? 1 : CHANNELS);
    localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NCH - 1);

    // Unpacked view of the incoming transaction.
    logic [LEVELS_W-1:0] in_levels;
    logic [TIME_W-1:0]   in_now;
    logic                in_pg;
    logic [CH_W-1:0]     in_pch;
    logic [CNT_W-1:0]    in_pcount;
    t_mode               in_mode;

    assign in_levels = i_s_axis_tdata[S_LEVELS_LSB +: LEVELS_W];
    assign in_now    = i_s_axis_tdata[S_NOW_LSB +: TIME_W];
    assign in_pg     = i_s_axis_tdata[S_PG_BIT];
    assign in_pch    = i_s_axis_tdata[S_PCH_LSB +: CH_W];
    assign in_pcount = i_s_axis_tdata[S_PCNT_LSB +: CNT_W];
    assign in_mode   = t_mode'(i_s_axis_tuser);

    // Per-channel state.
    logic              r_active   [NCH];
    logic [CNT_W-1:0]  r_count    [NCH];
    logic [TIME_W-1:0] r_on_stamp [NCH];
    logic [TIME_W-1:0] r_off_stamp[NCH];
    logic [TIME_W-1:0] r_on_time  [NCH];
    logic [TIME_W-1:0] r_off_time [NCH];

    logic              n_active   [NCH];
    logic [CNT_W-1:0]  n_count    [NCH];
    logic [TIME_W-1:0] n_on_stamp [NCH];
    logic [TIME_W-1:0] n_off_stamp[NCH];
    logic [TIME_W-1:0] n_on_time  [NCH];
    logic [TIME_W-1:0] n_off_time [NCH];
    t_chan_result      n_res      [NCH];

    // Snapshot buffer drained on the master side.
    t_chan_result      r_snap[NCH];
    logic              r_busy;
    logic [IDX_W-1:0]  r_idx;
    logic              r_pg;

    logic in_acc;
    logic out_acc;
    logic out_last;
    logic poll_acc;
    logic preload_acc;
    logic preload_hit;

    assign out_last        = (r_idx == LAST_IDX);
    assign o_s_axis_tready = !r_busy || (i_m_axis_tready && out_last);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc         = r_busy && i_m_axis_tready;
    assign poll_acc        = in_acc && (in_mode == MODE_POLL);
    assign preload_acc     = in_acc && (in_mode == MODE_PRELOAD);
    assign preload_hit     = preload_acc && (32'(in_pch) < 32'(NCH));

    // Lane update: each channel is independent of the others.
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            n_active[i]    = r_active[i];
            n_count[i]     = r_count[i];
            n_on_stamp[i]  = r_on_stamp[i];
            n_off_stamp[i] = r_off_stamp[i];
            n_on_time[i]   = r_on_time[i];
            n_off_time[i]  = r_off_time[i];
            n_res[i].rise  = 1'b0;
            n_res[i].fall  = 1'b0;
            if (poll_acc && in_pg) begin
                if (!in_levels[i]) begin
                    if (!r_active[i]) begin
                        n_count[i]    = r_count[i] + CNT_W'(1);
                        n_active[i]   = 1'b1;
                        n_off_time[i] = '0;
                        n_on_stamp[i] = in_now;
                        n_on_time[i]  = '0;
                        n_res[i].rise = 1'b1;
                    end else begin
                        n_on_time[i] = in_now - r_on_stamp[i];
                    end
                end else begin
                    if (r_active[i]) begin
                        n_active[i]    = 1'b0;
                        n_off_stamp[i] = in_now;
                        n_on_time[i]   = '0;
                        n_off_time[i]  = '0;
                        n_res[i].fall  = 1'b1;
                    end else if (r_count[i] != '0) begin
                        n_off_time[i] = in_now - r_off_stamp[i];
                    end else begin
                        n_off_time[i] = '0;
                    end
                end
            end
            if (preload_hit && (in_pch[IDX_W-1:0] == IDX_W'(i))) begin
                n_count[i] = in_pcount;
            end
            n_res[i].count    = n_count[i];
            n_res[i].on_time  = n_on_time[i];
            n_res[i].off_time = n_off_time[i];
            n_res[i].active   = n_active[i];
        end
    end

    // Channel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                r_active[i]    <= 1'b0;
                r_count[i]     <= '0;
                r_on_stamp[i]  <= '0;
                r_off_stamp[i] <= '0;
                r_on_time[i]   <= '0;
                r_off_time[i]  <= '0;
            end
        end else begin
            for (int i = 0; i < NCH; i++) begin
                r_active[i]    <= n_active[i];
                r_count[i]     <= n_count[i];
                r_on_stamp[i]  <= n_on_stamp[i];
                r_off_stamp[i] <= n_off_stamp[i];
                r_on_time[i]   <= n_on_time[i];
                r_off_time[i]  <= n_off_time[i];
            end
        end
    end

    // Drain control. A new poll on the last beat reloads the buffer at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (poll_acc) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_acc) begin
            if (out_last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // Snapshot payload, no reset needed.
    always_ff @(posedge i_clk) begin
        if (poll_acc) begin
            r_pg <= in_pg;
            for (int i = 0; i < NCH; i++) begin
                r_snap[i] <= n_res[i];
            end
        end
    end

    // Master side.
    t_chan_result cur;
    assign cur = r_snap[r_idx];

    always_comb begin
        o_m_axis_tdata                           = '0;
        o_m_axis_tdata[M_CH_LSB +: CH_W]         = CH_W'(r_idx);
        o_m_axis_tdata[M_CNT_LSB +: CNT_W]       = cur.count;
        o_m_axis_tdata[M_ON_LSB +: TIME_W]       = cur.on_time;
        o_m_axis_tdata[M_OFF_LSB +: TIME_W]      = cur.off_time;
        o_m_axis_tdata[M_ACT_BIT]                = cur.active;
        o_m_axis_tdata[M_RISE_BIT]               = cur.rise;
        o_m_axis_tdata[M_FALL_BIT]               = cur.fall;
        o_m_axis_tdata[M_POLL_BIT]               = r_pg;
    end

    assign o_m_axis_tvalid = r_busy;
    assign o_m_axis_tlast  = out_last;

    // An accepted poll starts its results at channel 0 in the next cycle.
    a_poll_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        poll_acc |=> (r_busy && r_idx == '0))
        else $error("poll did not start its result burst at channel 0");

    // A preload taken while idle produces no results.
    a_preload_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (preload_acc && !r_busy) |=> !r_busy)
        else $error("preload produced output");

    // A taken result that is not the last moves on to the next channel.
    a_idx_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && !out_last && !poll_acc) |=>
            (r_busy && r_idx == $past(r_idx) + IDX_W'(1)))
        else $error("channel sequence skipped or repeated");

    // Without power good no edge is reported.
    a_no_edge_unpowered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_pg) |-> (!cur.rise && !cur.fall))
        else $error("edge reported while power not good");

    // An activation edge leaves the channel active, a release leaves it inactive.
    a_edge_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((!cur.rise || cur.active) && (!cur.fall || !cur.active)))
        else $error("edge flag disagrees with the active flag");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pulse_counter_with_durations_unit
// Sends poll and preload transactions with random gaps while the result side
// stalls at random. A local copy of the per-channel counter state predicts
// the eight channel reports of every poll, and each report is checked field
// by field.
// ----------------------------------------------------------------------------
module testbench;
    import pcwd_pkg::*;

    // The run is cut off here.
    localparam int CYCLE_LIMIT = 200000;
    // The long receiver hold-off starts once this many reports have arrived.
    localparam int HOLD_AT     = 200;
    localparam int HOLD_LEN    = 150;
    // Reports in this window are taken with no receiver stalls at all.
    localparam int BURST_LO    = 400;
    localparam int BURST_HI    = 560;
    localparam int NUM_RANDOM  = 100;

    // One slave-side transaction plus how the driver should pace it.
    typedef struct {
        t_mode            mode;
        logic [7:0]       levels;
        logic [31:0]      now_ms;
        logic             power_good;
        logic [CH_W-1:0]  preload_ch;
        logic [31:0]      preload_cnt;
        int unsigned      gap;          // idle cycles after this one is taken
        bit               settle_first; // hold until every report has come
    } t_poll_item;

    // One channel report as it should appear on the master side.
    typedef struct {
        logic [CH_W-1:0] channel;
        logic [31:0]     count;
        logic [31:0]     on_ms;
        logic [31:0]     off_ms;
        logic            active;
        logic            rise;
        logic            fall;
        logic            polled;
        logic            last_ch;
    } t_report;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [S_TDATA_W-1:0] s_data = '0;
    logic                 s_user = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [M_TDATA_W-1:0] m_data;
    logic                 m_last;

    t_poll_item  poll_queue[$];
    t_report     owed_reports[$];

    // Predicted counter state, one entry per channel.
    logic        chan_active[8];
    logic [31:0] chan_count[8];
    logic [31:0] chan_on_stamp[8];
    logic [31:0] chan_off_stamp[8];
    logic [31:0] chan_on_ms[8];
    logic [31:0] chan_off_ms[8];

    int unsigned mismatches = 0;
    int unsigned reports_checked = 0;
    int unsigned polls_sent = 0;
    int unsigned preloads_sent = 0;
    int unsigned cycles = 0;

    pulse_counter_with_durations_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    always #2 i_clk = ~i_clk;

    // Gives up if the run hangs, for example when a report never arrives.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d reports still owed", $realtime,
                     owed_reports.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Packs the slave-side fields; the padding bits above them stay zero.
    function automatic logic [S_TDATA_W-1:0] pack_item(input t_poll_item it);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[S_LEVELS_LSB +: LEVELS_W] = it.levels;
        d[S_NOW_LSB +: TIME_W]      = it.now_ms;
        d[S_PG_BIT]                 = it.power_good;
        d[S_PCH_LSB +: CH_W]        = it.preload_ch;
        d[S_PCNT_LSB +: CNT_W]      = it.preload_cnt;
        return d;
    endfunction

    // Applies one poll to the predicted state and queues the eight reports.
    // A channel that goes active bumps its count and restarts its on-time; one
    // that goes inactive restarts its off-time. Holding levels report the time
    // since the stored stamp, with modulo-2^32 subtraction covering wrap. The
    // off-time is held at zero while the count is zero. With power not good
    // nothing changes and the stored values are reported as they are.
    task automatic advance_channels(input t_poll_item it);
        t_report r;
        logic    hit;
        for (int ch = 0; ch < 8; ch++) begin
            r = '{default: '0};
            if (it.power_good) begin
                hit = ~it.levels[ch];
                if (hit && !chan_active[ch]) begin
                    chan_count[ch]    = chan_count[ch] + 32'd1;
                    chan_active[ch]   = 1'b1;
                    chan_off_ms[ch]   = '0;
                    chan_on_stamp[ch] = it.now_ms;
                    chan_on_ms[ch]    = '0;
                    r.rise            = 1'b1;
                end else if (hit) begin
                    chan_on_ms[ch] = it.now_ms - chan_on_stamp[ch];
                end else if (chan_active[ch]) begin
                    chan_active[ch]    = 1'b0;
                    chan_off_stamp[ch] = it.now_ms;
                    chan_on_ms[ch]     = '0;
                    chan_off_ms[ch]    = '0;
                    r.fall             = 1'b1;
                end else begin
                    chan_off_ms[ch] = (chan_count[ch] != 0) ?
                                      it.now_ms - chan_off_stamp[ch] : '0;
                end
            end
            r.channel = ch[CH_W-1:0];
            r.count   = chan_count[ch];
            r.on_ms   = chan_on_ms[ch];
            r.off_ms  = chan_off_ms[ch];
            r.active  = chan_active[ch];
            r.polled  = it.power_good;
            r.last_ch = (ch == 7);
            owed_reports.push_back(r);
        end
    endtask

    // Driver: presents queued items, honoring each item's gap. An item marked
    // settle_first is held back until the previous transaction is gone and no
    // report is owed, which lets the unit drain completely.
    int unsigned wait_cnt = 0;
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            s_valid  <= 1'b0;
            wait_cnt <= 0;
        end else if (!s_valid || s_ready) begin
            if (wait_cnt != 0) begin
                wait_cnt <= wait_cnt - 1;
                s_valid  <= 1'b0;
            end else if (poll_queue.size() != 0 &&
                         (!poll_queue[0].settle_first ||
                          (!s_valid && owed_reports.size() == 0))) begin
                s_valid  <= 1'b1;
                s_data   <= pack_item(poll_queue[0]);
                s_user   <= poll_queue[0].mode;
                wait_cnt <= poll_queue[0].gap;
                void'(poll_queue.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: after each report it may stall at random, except in a burst
    // window where it never stalls. Once, it holds off for a long stretch so
    // that the unit backs up and stops taking polls.
    int unsigned rx_seen = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    always @(posedge i_clk) begin : receiver
        int unsigned draw;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                rx_seen <= rx_seen + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (!hold_done && rx_seen >= HOLD_AT) begin
                hold_left <= HOLD_LEN - 1;
                hold_done <= 1'b1;
                m_ready   <= 1'b0;
            end else if (m_valid && m_ready) begin
                draw = (rx_seen >= BURST_LO && rx_seen < BURST_HI) ?
                       0 : $urandom_range(0, 7);
                if (draw == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready    <= 1'b0;
                    stall_left <= draw - 1;
                end
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: folds each accepted slave transaction into the prediction,
    // then checks each accepted report against the oldest one owed.
    always @(posedge i_clk) begin : monitor
        t_poll_item it;
        t_report    want;
        t_report    got;
        if (i_rst_n) begin
            if (s_valid && s_ready) begin
                it.mode        = t_mode'(s_user);
                it.levels      = s_data[S_LEVELS_LSB +: LEVELS_W];
                it.now_ms      = s_data[S_NOW_LSB +: TIME_W];
                it.power_good  = s_data[S_PG_BIT];
                it.preload_ch  = s_data[S_PCH_LSB +: CH_W];
                it.preload_cnt = s_data[S_PCNT_LSB +: CNT_W];
                if (it.mode == MODE_PRELOAD) begin
                    // Every channel index exists, so a preload always lands.
                    chan_count[it.preload_ch] = it.preload_cnt;
                    preloads_sent++;
                end else begin
                    advance_channels(it);
                    polls_sent++;
                end
            end
            if (m_valid && m_ready) begin
                got.channel = m_data[M_CH_LSB +: CH_W];
                got.count   = m_data[M_CNT_LSB +: CNT_W];
                got.on_ms   = m_data[M_ON_LSB +: TIME_W];
                got.off_ms  = m_data[M_OFF_LSB +: TIME_W];
                got.active  = m_data[M_ACT_BIT];
                got.rise    = m_data[M_RISE_BIT];
                got.fall    = m_data[M_FALL_BIT];
                got.polled  = m_data[M_POLL_BIT];
                got.last_ch = m_last;
                reports_checked++;
                if (owed_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected report, expected none, got ch %0d cnt %h",
                             $realtime, got.channel, got.count);
                end else begin
                    want = owed_reports.pop_front();
                    if (got.channel !== want.channel) begin
                        mismatches++;
                        $display("%0t: channel expected %0d got %0d", $realtime,
                                 want.channel, got.channel);
                    end
                    if (got.count !== want.count) begin
                        mismatches++;
                        $display("%0t: ch %0d event_count expected %h got %h",
                                 $realtime, want.channel, want.count, got.count);
                    end
                    if (got.on_ms !== want.on_ms) begin
                        mismatches++;
                        $display("%0t: ch %0d on_time_ms expected %h got %h",
                                 $realtime, want.channel, want.on_ms, got.on_ms);
                    end
                    if (got.off_ms !== want.off_ms) begin
                        mismatches++;
                        $display("%0t: ch %0d off_time_ms expected %h got %h",
                                 $realtime, want.channel, want.off_ms, got.off_ms);
                    end
                    if (got.active !== want.active) begin
                        mismatches++;
                        $display("%0t: ch %0d is_active expected %b got %b",
                                 $realtime, want.channel, want.active, got.active);
                    end
                    if (got.rise !== want.rise) begin
                        mismatches++;
                        $display("%0t: ch %0d became_active expected %b got %b",
                                 $realtime, want.channel, want.rise, got.rise);
                    end
                    if (got.fall !== want.fall) begin
                        mismatches++;
                        $display("%0t: ch %0d became_inactive expected %b got %b",
                                 $realtime, want.channel, want.fall, got.fall);
                    end
                    if (got.polled !== want.polled) begin
                        mismatches++;
                        $display("%0t: ch %0d polled expected %b got %b",
                                 $realtime, want.channel, want.polled, got.polled);
                    end
                    if (got.last_ch !== want.last_ch) begin
                        mismatches++;
                        $display("%0t: ch %0d tlast expected %b got %b",
                                 $realtime, want.channel, want.last_ch, got.last_ch);
                    end
                end
            end
        end
    end

    // Queues a poll or a preload; unused fields carry random junk so that
    // their bits toggle without changing the outcome.
    task automatic add_poll(input logic [7:0] lv, input logic [31:0] now,
                            input logic pg, input bit settle);
        t_poll_item it;
        it.mode         = MODE_POLL;
        it.levels       = lv;
        it.now_ms       = now;
        it.power_good   = pg;
        it.preload_ch   = CH_W'($urandom_range(0, 7));
        it.preload_cnt  = $urandom();
        it.gap          = $urandom_range(0, 7);
        it.settle_first = settle;
        poll_queue.push_back(it);
    endtask

    task automatic add_preload(input logic [CH_W-1:0] ch, input logic [31:0] cnt,
                               input logic pg);
        t_poll_item it;
        it.mode         = MODE_PRELOAD;
        it.levels       = 8'($urandom_range(0, 255));
        it.now_ms       = $urandom();
        it.power_good   = pg;
        it.preload_ch   = ch;
        it.preload_cnt  = cnt;
        it.gap          = $urandom_range(0, 7);
        it.settle_first = 1'b0;
        poll_queue.push_back(it);
    endtask

    initial begin : stimulus
        logic [7:0]  lv;
        logic [31:0] now;
        logic [7:0]  flips;
        int unsigned pick;

        for (int ch = 0; ch < 8; ch++) begin
            chan_active[ch]    = 1'b0;
            chan_count[ch]     = '0;
            chan_on_stamp[ch]  = '0;
            chan_off_stamp[ch] = '0;
            chan_on_ms[ch]     = '0;
            chan_off_ms[ch]    = '0;
        end

        // Directed part. All channels idle before any count: off-time is zero.
        add_poll(8'hFF, 32'd0, 1'b1, 1'b0);
        // Every channel activates, holds, releases and stays released.
        add_poll(8'h00, 32'd100, 1'b1, 1'b0);
        add_poll(8'h00, 32'd350, 1'b1, 1'b0);
        add_poll(8'hFF, 32'd1000, 1'b1, 1'b0);
        add_poll(8'hFF, 32'd1600, 1'b1, 1'b0);
        // Power not good: the pins say active but nothing may change.
        add_poll(8'h00, 32'd2000, 1'b0, 1'b0);
        // Even channels activate just below the time wrap, then hold across it.
        add_poll(8'hAA, 32'hFFFF_FFF0, 1'b1, 1'b0);
        add_poll(8'hAA, 32'h0000_0010, 1'b1, 1'b0);
        // Preloads: full count on channel 7 so the next activation wraps it to
        // zero, and zero on channel 0 so its off-time is held at zero again.
        add_preload(3'd7, 32'hFFFF_FFFF, 1'b1);
        add_preload(3'd0, 32'h0000_0000, 1'b1);
        add_poll(8'h55, 32'h0000_0020, 1'b1, 1'b0);
        add_poll(8'hFF, 32'h0000_0080, 1'b1, 1'b0);
        add_poll(8'hFF, 32'h0000_0200, 1'b1, 1'b0);
        // A preload with power not good still writes the count.
        add_preload(3'd3, 32'h8000_0000, 1'b0);
        add_poll(8'h00, 32'h1234_5678, 1'b0, 1'b1);
        add_poll(8'h7F, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_poll(8'h7F, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_preload(3'd5, 32'h0000_0001, 1'b1);
        add_poll(8'h80, 32'h8000_0000, 1'b1, 1'b0);
        add_poll(8'hFF, 32'h8000_0001, 1'b1, 1'b0);

        // Random part: mostly slow-moving pin levels and rising time, so
        // channels hold for several polls; now and then a jump in time, a
        // power dropout or a preload.
        lv  = 8'hFF;
        now = $urandom();
        for (int n = 0; n < NUM_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                add_preload(CH_W'($urandom_range(0, 7)),
                            ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom(),
                            1'($urandom_range(0, 1)));
            end else begin
                flips = 8'($urandom_range(0, 255) & $urandom_range(0, 255));
                lv    = (pick < 15) ? 8'($urandom_range(0, 255)) : lv ^ flips;
                now   = (pick < 20) ? $urandom() : now + $urandom_range(1, 5000);
                add_poll(lv, now, pick >= 25, (n == 50 || n == 90));
            end
            // A stretch of back-to-back transactions with no sender gaps.
            if (n >= 20 && n < 45)
                poll_queue[poll_queue.size() - 1].gap = 0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last transaction to be taken and every report to come,
        // then give the unit time to show any stray extra report.
        while (poll_queue.size() != 0 || s_valid || owed_reports.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d polls and %0d preloads; %0d channel reports checked.",
                 polls_sent, preloads_sent, reports_checked);
        $display("Included power dropouts, time wrap, count wrap and a long output stall.");
        if (mismatches == 0 && owed_reports.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
